### src/mexp_pkg.sv
// Shared constants for the modular exponentiation pipeline.
`default_nettype none

package mexp_pkg;

  localparam int BASE_WIDTH    = 32;
  localparam int EXP_WIDTH_DEF = 32;
  localparam int MOD_WIDTH_DEF = 16;
  localparam int BYTE_WIDTH    = 8;

endpackage

`default_nettype wire

### src/mexp_red_cell.sv
// One restoring-reduction cell: shifts one bit into each lane remainder and subtracts the modulus where it fits.
`default_nettype none

module mexp_red_cell #(
  parameter int MOD_WIDTH   = 16,
  parameter int SHIFT_WIDTH = 16,
  parameter int LANES       = 1,
  parameter int SIDE_WIDTH  = 1
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           en,
  input  wire logic                           in_valid,
  input  wire logic [LANES*MOD_WIDTH-1:0]     in_rem,
  input  wire logic [LANES*SHIFT_WIDTH-1:0]   in_rest,
  input  wire logic [MOD_WIDTH-1:0]           in_mod,
  input  wire logic [SIDE_WIDTH-1:0]          in_side,
  output logic                                out_valid,
  output logic [LANES*MOD_WIDTH-1:0]          out_rem,
  output logic [LANES*SHIFT_WIDTH-1:0]        out_rest,
  output logic [MOD_WIDTH-1:0]                out_mod,
  output logic [SIDE_WIDTH-1:0]               out_side
);

  logic                          valid_r;
  logic [LANES*MOD_WIDTH-1:0]    rem_r, rem_nxt;
  logic [LANES*SHIFT_WIDTH-1:0]  rest_r, rest_nxt;
  logic [MOD_WIDTH-1:0]          mod_r;
  logic [SIDE_WIDTH-1:0]         side_r;

  always_comb begin
    logic [MOD_WIDTH:0] t;
    logic [MOD_WIDTH:0] d;
    rem_nxt  = '0;
    rest_nxt = '0;
    for (int l = 0; l < LANES; l++) begin
      t = {in_rem[l*MOD_WIDTH +: MOD_WIDTH], in_rest[l*SHIFT_WIDTH + SHIFT_WIDTH - 1]};
      d = t - {1'b0, in_mod};
      if (t >= {1'b0, in_mod}) begin
        rem_nxt[l*MOD_WIDTH +: MOD_WIDTH] = d[MOD_WIDTH-1:0];
      end else begin
        rem_nxt[l*MOD_WIDTH +: MOD_WIDTH] = t[MOD_WIDTH-1:0];
      end
      rest_nxt[l*SHIFT_WIDTH +: SHIFT_WIDTH] =
        {in_rest[l*SHIFT_WIDTH +: SHIFT_WIDTH-1], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      rest_r <= rest_nxt;
      mod_r  <= in_mod;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_rest  = rest_r;
  assign out_mod   = mod_r;
  assign out_side  = side_r;

endmodule

`default_nettype wire

### src/mexp_mul_cell.sv
// Multiply cell: forms the accumulator and square products for one exponent bit.
`default_nettype none

module mexp_mul_cell #(
  parameter int EXP_WIDTH = 32,
  parameter int MOD_WIDTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             en,
  input  wire logic                             in_valid,
  input  wire logic [MOD_WIDTH-1:0]             in_acc,
  input  wire logic [MOD_WIDTH-1:0]             in_sq,
  input  wire logic [MOD_WIDTH-1:0]             in_mod,
  input  wire logic [EXP_WIDTH-1:0]             in_exp,
  output logic                                  out_valid,
  output logic [4*MOD_WIDTH-1:0]                out_prod,  // acc product, then square product
  output logic [MOD_WIDTH-1:0]                  out_mod,
  output logic [EXP_WIDTH+MOD_WIDTH:0]          out_side   // acc, skip, shifted exponent
);

  logic                          valid_r;
  logic [2*MOD_WIDTH-1:0]        pacc_r, pacc_nxt;
  logic [2*MOD_WIDTH-1:0]        psq_r, psq_nxt;
  logic [MOD_WIDTH-1:0]          mod_r;
  logic [EXP_WIDTH+MOD_WIDTH:0]  side_r, side_nxt;

  always_comb begin
    pacc_nxt = (2*MOD_WIDTH)'(in_acc) * (2*MOD_WIDTH)'(in_sq);
    psq_nxt  = (2*MOD_WIDTH)'(in_sq) * (2*MOD_WIDTH)'(in_sq);
    side_nxt = {(in_exp >> 1), ~in_exp[0], in_acc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pacc_r <= pacc_nxt;
      psq_r  <= psq_nxt;
      mod_r  <= in_mod;
      side_r <= side_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_prod  = {psq_r, pacc_r};
  assign out_mod   = mod_r;
  assign out_side  = side_r;

endmodule

`default_nettype wire

### src/mexp_bit_slice.sv
// One exponent bit: a multiply cell followed by a chain of reduction cells.
`default_nettype none

module mexp_bit_slice #(
  parameter int EXP_WIDTH = 32,
  parameter int MOD_WIDTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire logic [MOD_WIDTH-1:0]  in_acc,
  input  wire logic [MOD_WIDTH-1:0]  in_sq,
  input  wire logic [MOD_WIDTH-1:0]  in_mod,
  input  wire logic [EXP_WIDTH-1:0]  in_exp,
  output logic                       out_valid,
  output logic [MOD_WIDTH-1:0]       out_acc,
  output logic [MOD_WIDTH-1:0]       out_sq,
  output logic [MOD_WIDTH-1:0]       out_mod,
  output logic [EXP_WIDTH-1:0]       out_exp
);

  localparam int SIDE_WIDTH = EXP_WIDTH + MOD_WIDTH + 1;

  logic                         v    [0:MOD_WIDTH];
  logic [2*MOD_WIDTH-1:0]       rem  [0:MOD_WIDTH];
  logic [2*MOD_WIDTH-1:0]       rest [0:MOD_WIDTH];
  logic [MOD_WIDTH-1:0]         md   [0:MOD_WIDTH];
  logic [SIDE_WIDTH-1:0]        side [0:MOD_WIDTH];
  logic [4*MOD_WIDTH-1:0]       prod;

  mexp_mul_cell #(
    .EXP_WIDTH (EXP_WIDTH),
    .MOD_WIDTH (MOD_WIDTH)
  ) u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_acc    (in_acc),
    .in_sq     (in_sq),
    .in_mod    (in_mod),
    .in_exp    (in_exp),
    .out_valid (v[0]),
    .out_prod  (prod),
    .out_mod   (md[0]),
    .out_side  (side[0])
  );

  assign rem[0]  = {prod[4*MOD_WIDTH-1:3*MOD_WIDTH], prod[2*MOD_WIDTH-1:MOD_WIDTH]};
  assign rest[0] = {prod[3*MOD_WIDTH-1:2*MOD_WIDTH], prod[MOD_WIDTH-1:0]};

  for (genvar s = 0; s < MOD_WIDTH; s++) begin : g_red
    mexp_red_cell #(
      .MOD_WIDTH   (MOD_WIDTH),
      .SHIFT_WIDTH (MOD_WIDTH),
      .LANES       (2),
      .SIDE_WIDTH  (SIDE_WIDTH)
    ) u_red (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (v[s]),
      .in_rem    (rem[s]),
      .in_rest   (rest[s]),
      .in_mod    (md[s]),
      .in_side   (side[s]),
      .out_valid (v[s+1]),
      .out_rem   (rem[s+1]),
      .out_rest  (rest[s+1]),
      .out_mod   (md[s+1]),
      .out_side  (side[s+1])
    );
  end

  // skip: exponent bit clear, keep the accumulator as it was
  assign out_valid = v[MOD_WIDTH];
  assign out_acc   = side[MOD_WIDTH][MOD_WIDTH] ? side[MOD_WIDTH][MOD_WIDTH-1:0]
                                                : rem[MOD_WIDTH][MOD_WIDTH-1:0];
  assign out_sq    = rem[MOD_WIDTH][2*MOD_WIDTH-1:MOD_WIDTH];
  assign out_mod   = md[MOD_WIDTH];
  assign out_exp   = side[MOD_WIDTH][SIDE_WIDTH-1:MOD_WIDTH+1];

endmodule

`default_nettype wire

### src/modular_exponentiation.sv
// Top level: pipelined right-to-left square-and-multiply modular exponentiation.
//
// Input channel in_*: one transfer carries base, exponent and modulus in in_tdata.
// Output channel out_*: one transfer per input, result in out_tdata and the
// zero-modulus flag in out_tuser. A zero modulus gives result 0 with the flag set.
// The datapath is a chain of cells that all advance together: BASE_WIDTH
// reduction cells bring the base below the modulus, then each exponent bit has
// one multiply cell and MOD_WIDTH reduction cells (one remainder bit per cell).
// Throughput: one item per cycle while the skid register is empty; the chain holds while it is full.
// Results leave through an output register backed by a skid register. When the
// receiver holds out_tready low, the chain keeps flowing until the skid register
// fills; in_tready then drops and the chain holds until the output is taken.
// Reset (synchronous, rst_n low) empties the chain and both output registers.
`default_nettype none

module modular_exponentiation #(
  parameter int EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEF,
  parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // base, exponent, modulus (lowest bits first), zero padded
  input  wire logic [((mexp_pkg::BASE_WIDTH + EXP_WIDTH + MOD_WIDTH
                      + mexp_pkg::BYTE_WIDTH - 1) / mexp_pkg::BYTE_WIDTH)
                     * mexp_pkg::BYTE_WIDTH - 1:0] in_tdata,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // result, zero padded
  output logic [((MOD_WIDTH + mexp_pkg::BYTE_WIDTH - 1) / mexp_pkg::BYTE_WIDTH)
                * mexp_pkg::BYTE_WIDTH - 1:0] out_tdata,
  // bad_modulus
  output logic      out_tuser
);

  import mexp_pkg::*;

  localparam int OUT_W = ((MOD_WIDTH + BYTE_WIDTH - 1) / BYTE_WIDTH) * BYTE_WIDTH;

  logic                  en;
  logic                  in_xfer;

  logic                  bv    [0:BASE_WIDTH];
  logic [MOD_WIDTH-1:0]  brem  [0:BASE_WIDTH];
  logic [BASE_WIDTH-1:0] brest [0:BASE_WIDTH];
  logic [MOD_WIDTH-1:0]  bmod  [0:BASE_WIDTH];
  logic [EXP_WIDTH-1:0]  bexp  [0:BASE_WIDTH];

  logic                  ev    [0:EXP_WIDTH];
  logic [MOD_WIDTH-1:0]  eacc  [0:EXP_WIDTH];
  logic [MOD_WIDTH-1:0]  esq   [0:EXP_WIDTH-1];
  logic [MOD_WIDTH-1:0]  emod  [0:EXP_WIDTH];
  logic [EXP_WIDTH-1:0]  eexp  [0:EXP_WIDTH-1];

  logic                  pipe_v;
  logic [MOD_WIDTH-1:0]  pipe_res;
  logic                  pipe_bad;

  logic                  o_valid_r;
  logic [MOD_WIDTH-1:0]  o_res_r;
  logic                  o_bad_r;
  logic                  s_full_r;
  logic [MOD_WIDTH-1:0]  s_res_r;
  logic                  s_bad_r;

  assign en        = ~s_full_r;
  assign in_tready = ~s_full_r;
  assign in_xfer   = in_tvalid & in_tready;

  assign bv[0]    = in_xfer;
  assign brem[0]  = '0;
  assign brest[0] = in_tdata[BASE_WIDTH-1:0];
  assign bexp[0]  = in_tdata[BASE_WIDTH +: EXP_WIDTH];
  assign bmod[0]  = in_tdata[BASE_WIDTH + EXP_WIDTH +: MOD_WIDTH];

  for (genvar b = 0; b < BASE_WIDTH; b++) begin : g_base
    mexp_red_cell #(
      .MOD_WIDTH   (MOD_WIDTH),
      .SHIFT_WIDTH (BASE_WIDTH),
      .LANES       (1),
      .SIDE_WIDTH  (EXP_WIDTH)
    ) u_red (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (bv[b]),
      .in_rem    (brem[b]),
      .in_rest   (brest[b]),
      .in_mod    (bmod[b]),
      .in_side   (bexp[b]),
      .out_valid (bv[b+1]),
      .out_rem   (brem[b+1]),
      .out_rest  (brest[b+1]),
      .out_mod   (bmod[b+1]),
      .out_side  (bexp[b+1])
    );
  end

  assign ev[0]   = bv[BASE_WIDTH];
  assign eacc[0] = MOD_WIDTH'(1);
  assign esq[0]  = brem[BASE_WIDTH];
  assign emod[0] = bmod[BASE_WIDTH];
  assign eexp[0] = bexp[BASE_WIDTH];

  for (genvar k = 0; k < EXP_WIDTH; k++) begin : g_bit
    if (k < EXP_WIDTH - 1) begin : g_mid
      mexp_bit_slice #(
        .EXP_WIDTH (EXP_WIDTH),
        .MOD_WIDTH (MOD_WIDTH)
      ) u_slice (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ev[k]),
        .in_acc    (eacc[k]),
        .in_sq     (esq[k]),
        .in_mod    (emod[k]),
        .in_exp    (eexp[k]),
        .out_valid (ev[k+1]),
        .out_acc   (eacc[k+1]),
        .out_sq    (esq[k+1]),
        .out_mod   (emod[k+1]),
        .out_exp   (eexp[k+1])
      );
    end else begin : g_last
      mexp_bit_slice #(
        .EXP_WIDTH (EXP_WIDTH),
        .MOD_WIDTH (MOD_WIDTH)
      ) u_slice (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ev[k]),
        .in_acc    (eacc[k]),
        .in_sq     (esq[k]),
        .in_mod    (emod[k]),
        .in_exp    (eexp[k]),
        .out_valid (ev[k+1]),
        .out_acc   (eacc[k+1]),
        .out_sq    (),
        .out_mod   (emod[k+1]),
        .out_exp   ()
      );
    end
  end

  assign pipe_v   = ev[EXP_WIDTH] & en;
  assign pipe_bad = (emod[EXP_WIDTH] == '0);
  assign pipe_res = pipe_bad ? '0 : eacc[EXP_WIDTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
      s_full_r  <= 1'b0;
    end else if (s_full_r) begin
      if (out_tready) begin
        s_full_r <= 1'b0;
      end
    end else if (!o_valid_r || out_tready) begin
      o_valid_r <= pipe_v;
    end else if (pipe_v) begin
      s_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_full_r) begin
      if (out_tready) begin
        o_res_r <= s_res_r;
        o_bad_r <= s_bad_r;
      end
    end else if (!o_valid_r || out_tready) begin
      o_res_r <= pipe_res;
      o_bad_r <= pipe_bad;
    end else if (pipe_v) begin
      s_res_r <= pipe_res;
      s_bad_r <= pipe_bad;
    end
  end

  assign out_tvalid = o_valid_r;
  assign out_tdata  = OUT_W'(o_res_r);
  assign out_tuser  = o_bad_r;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    s_full_r |-> o_valid_r)
    else $error("skid register full while output register empty");

  a_bad_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid_r && o_bad_r) |-> (o_res_r == '0))
    else $error("zero modulus result not cleared");

  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s_full_r && !out_tready) |=> (s_full_r && $stable(s_res_r) && $stable(s_bad_r)))
    else $error("skid register changed while output stalled");

  a_reset_empties: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> (!o_valid_r && !s_full_r))
    else $error("output registers not empty after reset");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid_r && !out_tready && s_full_r) |-> !in_tready)
    else $error("input accepted with both output registers held");
`endif

endmodule

`default_nettype wire

### tb/sv/mexp_checker.sv
// Checker for the modular exponentiation block: predicts each result and compares transfers.
`timescale 1ns / 100ps

module mexp_checker #(
  parameter int IN_W  = 80,
  parameter int OUT_W = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  input  wire logic             in_tready,
  // base, exponent, modulus
  input  wire logic [IN_W-1:0]  in_tdata,
  input  wire logic             out_tvalid,
  input  wire logic             out_tready,
  // result
  input  wire logic [OUT_W-1:0] out_tdata,
  // bad_modulus
  input  wire logic             out_tuser,
  output int                    mismatches,
  output int                    pending
);

  localparam int BASE_W = mexp_pkg::BASE_WIDTH;
  localparam int EXP_W  = mexp_pkg::EXP_WIDTH_DEF;
  localparam int MOD_W  = mexp_pkg::MOD_WIDTH_DEF;

  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic [EXP_W-1:0]  exponent;
    logic [MOD_W-1:0]  modulus;
    logic [MOD_W-1:0]  value;
    logic              bad;
  } power_t;

  power_t pending_powers[$];
  int     fail_count = 0;

  function automatic power_t modpow_expect(input logic [BASE_W-1:0] b,
                                           input logic [EXP_W-1:0] e,
                                           input logic [MOD_W-1:0] m);
    power_t      r;
    logic [63:0] acc;
    logic [63:0] sq;
    logic [63:0] mm;
    r.base     = b;
    r.exponent = e;
    r.modulus  = m;
    mm = 64'(m);
    if (m == '0) begin
      r.value = '0;
      r.bad   = 1'b1;
    end else begin
      acc = 64'd1;
      sq  = 64'(b) % mm;
      for (int k = 0; k < EXP_W; k++) begin
        if (e[k]) acc = (acc * sq) % mm;
        sq = (sq * sq) % mm;
      end
      r.value = acc[MOD_W-1:0];
      r.bad   = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    power_t           want;
    logic [OUT_W-1:0] want_word;
    if (rst_n) begin
      // retire before predicting: a result never belongs to the item taken at the same edge
      if (out_tvalid && out_tready) begin
        if (pending_powers.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected transfer: result %0d bad_modulus %0b", out_tdata, out_tuser);
          fail_count++;
        end else begin
          want = pending_powers.pop_front();
          want_word = '0;
          want_word[MOD_W-1:0] = want.value;
          if (out_tdata !== want_word || out_tuser !== want.bad) begin
            if (fail_count < 10)
              $display("mismatch: %0d^%0d mod %0d expected result %0d bad_modulus %0b, got %0d %0b",
                       want.base, want.exponent, want.modulus, want_word, want.bad,
                       out_tdata, out_tuser);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready)
        pending_powers.push_back(modpow_expect(in_tdata[BASE_W-1:0],
                                               in_tdata[BASE_W +: EXP_W],
                                               in_tdata[BASE_W+EXP_W +: MOD_W]));
    end
    pending    <= pending_powers.size();
    mismatches <= fail_count;
  end

endmodule

### tb/sv/testbench.sv
// Testbench top: drives the modular exponentiation block and reports the verdict.
`timescale 1ns / 100ps

module testbench;

  localparam int BASE_W = mexp_pkg::BASE_WIDTH;
  localparam int EXP_W  = mexp_pkg::EXP_WIDTH_DEF;
  localparam int MOD_W  = mexp_pkg::MOD_WIDTH_DEF;
  localparam int BYTE_W = mexp_pkg::BYTE_WIDTH;
  localparam int IN_W   = ((BASE_W + EXP_W + MOD_W + BYTE_W - 1) / BYTE_W) * BYTE_W;
  localparam int OUT_W  = ((MOD_W + BYTE_W - 1) / BYTE_W) * BYTE_W;
  localparam int RANDOM_ITEMS = 1400;
  localparam int DRAIN_CYCLES = 700;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata   = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tuser;
  logic             calm       = 1'b0;
  int               mismatches;
  int               pending;

  modular_exponentiation uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  mexp_checker #(
    .IN_W  (IN_W),
    .OUT_W (OUT_W)
  ) checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 33);
    end
  end

  task automatic send_power(input logic [BASE_W-1:0] b, input logic [EXP_W-1:0] e,
                            input logic [MOD_W-1:0] m);
    logic [IN_W-1:0] word;
    logic [95:0]     noise;
    while (!calm && $urandom_range(99) < 33) begin
      noise = {$urandom, $urandom, $urandom};
      in_tvalid <= 1'b0;
      in_tdata  <= noise[IN_W-1:0];
      @(posedge clk);
    end
    word = '0;
    word[BASE_W-1:0]            = b;
    word[BASE_W +: EXP_W]       = e;
    word[BASE_W+EXP_W +: MOD_W] = m;
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [BASE_W-1:0] b;
    logic [EXP_W-1:0]  e;
    logic [MOD_W-1:0]  m;
    int                sel;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_power(32'd0, 32'd0, 16'd1);
    send_power(32'd0, 32'd0, 16'd0);
    send_power(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_power(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0);
    send_power(32'd5, 32'd1, 16'd1);
    send_power(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1);
    send_power(32'd0, 32'd5, 16'd7);
    send_power(32'd2, 32'd10, 16'd1000);
    send_power(32'd3, 32'hFFFF_FFFF, 16'd65521);
    send_power(32'hFFFF_FFFF, 32'd0, 16'hFFFF);
    send_power(32'd1, 32'h1234_5678, 16'd2);
    send_power(32'd65535, 32'd2, 16'hFFFF);
    send_power(32'd65534, 32'd2, 16'hFFFF);
    send_power(32'd7, 32'h8000_0000, 16'd13);
    send_power(32'h8000_0000, 32'd1, 16'h8000);
    send_power(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF);
    send_power(32'd0, 32'd0, 16'hFFFF);
    send_power(32'h5555_5555, 32'hAAAA_AAAA, 16'hAAAA);
    send_power(32'hAAAA_AAAA, 32'h5555_5555, 16'h5555);
    send_power(32'd123457, 32'd65537, 16'd2);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 350 || i == 1000) wait_drained();
      if (i == 500) calm <= 1'b1;
      if (i == 750) calm <= 1'b0;

      sel = $urandom_range(99);
      if (sel < 8)       m = '0;
      else if (sel < 16) m = MOD_W'($urandom_range(3, 1));
      else if (sel < 24) m = 16'hFFFF - MOD_W'($urandom_range(15));
      else if (sel < 40) m = MOD_W'($urandom_range(255, 2));
      else               m = MOD_W'($urandom_range(65535));

      sel = $urandom_range(99);
      if (sel < 10)      b = BASE_W'($urandom_range(3));
      else if (sel < 20) b = BASE_W'(m) * BASE_W'($urandom_range(65535));
      else if (sel < 25) b = 32'hFFFF_FFFF - BASE_W'($urandom_range(3));
      else               b = $urandom;

      sel = $urandom_range(99);
      if (sel < 10)      e = '0;
      else if (sel < 20) e = EXP_W'($urandom_range(16, 1));
      else if (sel < 25) e = 32'hFFFF_FFFF - EXP_W'($urandom_range(3));
      else if (sel < 30) e = EXP_W'(1) << $urandom_range(EXP_W - 1);
      else               e = $urandom;

      send_power(b, e, m);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### sim.f
src/mexp_pkg.sv
src/mexp_red_cell.sv
src/mexp_mul_cell.sv
src/mexp_bit_slice.sv
src/modular_exponentiation.sv
tb/sv/mexp_checker.sv
tb/sv/testbench.sv
